/* src/ermr_pkg.sv */
package ermr_pkg;

   // field widths
   localparam int PULSE_W = 16;
   localparam int DIST_W  = 17;
   localparam int SCALE_W = 12;
   localparam int CSR_W   = 17;
   localparam int CSR_IDX_W = 2;

   // distance arithmetic widths
   localparam int SUM_W  = PULSE_W + 1;
   localparam int PROD_W = SUM_W + SCALE_W;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W+1)'(256);
   localparam int                DIST_SHIFT = 9;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_PULSE   = 2'd0,
      CSR_MAX_PULSE   = 2'd1,
      CSR_FALLBACK    = 2'd2,
      CSR_SOUND_SCALE = 2'd3
   } csr_index_type;

   // register reset values
   localparam logic [PULSE_W-1:0] MIN_PULSE_RST   = 16'd117;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RST   = 16'd23323;
   localparam logic [DIST_W-1:0]  FALLBACK_RST    = 17'd512;
   localparam logic [SCALE_W-1:0] SOUND_SCALE_RST = 12'd1124;

endpackage

/* src/ermr_ram.sv */
module ermr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/echo_running_median_ranger_unit.sv */
// Sequence: an in-window width ranks each ring entry as pivot in ST_SCAN, then passes
//    ST_SUM, ST_MUL, ST_FIN and ST_DONE; a rejected width goes straight to ST_DONE.
// Flow: one item at a time; the next item is taken only once the result is loaded,
//    and a single comparator ranks every ring entry against every other.
// Reset (synchronous, active high) restores register defaults, marks all ring entries
//    as zero through per-entry valid bits and clears the write slots; no clearing pass.
module echo_running_median_ranger_unit #(
   parameter int WINDOW   = 20,
   parameter int CHANNELS = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration port
   input  logic                            csr_wr_en,
   input  logic [ermr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ermr_pkg::CSR_W-1:0]      csr_wdata,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_channel,
   input  logic [ermr_pkg::PULSE_W-1:0]    req_pulse_width,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ermr_pkg::DIST_W-1:0]     rsp_distance,
   output logic                            rsp_accepted
);

   import ermr_pkg::*;

   // only channels 0 and 1 can be addressed by the one-bit channel field
   localparam int SLOTS  = (CHANNELS < 2) ? CHANNELS : 2;
   localparam int DEPTH  = SLOTS * WINDOW;
   localparam int AW     = $clog2(DEPTH);
   localparam int IW     = $clog2(WINDOW);
   localparam int CW     = $clog2(WINDOW + 1);
   localparam int CNT_W  = $clog2(WINDOW + 3);
   localparam int K_LO   = ((WINDOW % 2) == 0) ? (WINDOW / 2 - 1) : (WINDOW / 2);
   localparam int K_HI   = WINDOW / 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SUM,
      ST_MUL,
      ST_FIN,
      ST_DONE
   } state_type;

   // configuration registers
   logic [PULSE_W-1:0] min_pulse_ff;
   logic [PULSE_W-1:0] max_pulse_ff;
   logic [DIST_W-1:0]  fallback_ff;
   logic [SCALE_W-1:0] scale_ff;

   // ring bookkeeping
   logic [IW-1:0]    slot_ff [SLOTS];
   logic [DEPTH-1:0] valid_ff;

   // sequencer state
   state_type          state_ff, state_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PULSE_W-1:0] vi_ff, vi_in;
   logic [CW-1:0]      lt_ff, lt_in;
   logic [CW-1:0]      le_ff, le_in;
   logic [PULSE_W-1:0] mid_lo_ff, mid_lo_in;
   logic [PULSE_W-1:0] mid_hi_ff, mid_hi_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DIST_W-1:0]  res_dist_ff, res_dist_in;
   logic               res_acc_ff, res_acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic               rsp_acc_ff, rsp_acc_in;

   // memory side
   logic               vld_rd_ff;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [AW-1:0]      ram_raddr;
   logic [IW-1:0]      rd_idx;
   logic [PULSE_W-1:0] ram_rdata;
   logic [PULSE_W-1:0] entry;

   // input decode
   logic          req_xfer;
   logic          ch_ok;
   logic          in_window;
   logic [AW-1:0] req_base;
   logic [IW-1:0] req_slot;

   // shared compare unit and distance scaling
   logic              cmp_lt;
   logic              cmp_eq;
   logic [PROD_W:0]   dist_round;
   logic [PROD_W-DIST_SHIFT:0] dist_full;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   assign ch_ok     = (32'(req_channel) < 32'(CHANNELS));
   assign in_window = ch_ok && (req_pulse_width >= min_pulse_ff)
                      && (req_pulse_width <= max_pulse_ff);
   assign req_base  = req_channel ? AW'(WINDOW) : '0;
   assign req_slot  = slot_ff[req_channel];

   // store an in-window width at the transfer edge
   assign ram_we    = req_xfer && in_window;
   assign ram_waddr = req_base + AW'(req_slot);

   // read the pivot first, then every entry of the ring in turn
   always_comb begin
      if (cnt_ff == '0 || cnt_ff > CNT_W'(WINDOW)) begin
         rd_idx = idx_ff;
      end else begin
         rd_idx = IW'(cnt_ff - CNT_W'(1));
      end
   end
   assign ram_raddr = base_ff + AW'(rd_idx);

   ermr_ram #(
      .WIDTH (PULSE_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_pulse_width),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // never-written entries read as zero
   assign entry  = vld_rd_ff ? ram_rdata : '0;
   assign cmp_lt = (entry < vi_ff);
   assign cmp_eq = (entry == vi_ff);

   // round half up, then drop the fraction bits
   assign dist_round = {1'b0, prod_ff} + ROUND_HALF;
   assign dist_full  = dist_round[PROD_W:DIST_SHIFT];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff <= MIN_PULSE_RST;
         max_pulse_ff <= MAX_PULSE_RST;
         fallback_ff  <= FALLBACK_RST;
         scale_ff     <= SOUND_SCALE_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_PULSE:   min_pulse_ff <= csr_wdata[PULSE_W-1:0];
            CSR_MAX_PULSE:   max_pulse_ff <= csr_wdata[PULSE_W-1:0];
            CSR_FALLBACK:    fallback_ff  <= csr_wdata[DIST_W-1:0];
            CSR_SOUND_SCALE: scale_ff     <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // write slots, valid bits and read-side valid tag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < SLOTS; c++) begin
            slot_ff[c] <= '0;
         end
         valid_ff  <= '0;
         vld_rd_ff <= 1'b0;
      end else begin
         vld_rd_ff <= valid_ff[ram_raddr];
         if (ram_we) begin
            valid_ff[ram_waddr] <= 1'b1;
            if (req_slot == IW'(WINDOW - 1)) begin
               slot_ff[req_channel] <= '0;
            end else begin
               slot_ff[req_channel] <= req_slot + IW'(1);
            end
         end
      end
   end

   // sequencer next state
   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      vi_in       = vi_ff;
      lt_in       = lt_ff;
      le_in       = le_ff;
      mid_lo_in   = mid_lo_ff;
      mid_hi_in   = mid_hi_ff;
      sum_in      = sum_ff;
      prod_in     = prod_ff;
      res_dist_in = res_dist_ff;
      res_acc_in  = res_acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_acc_in   = rsp_acc_ff;

      // result taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (in_window) begin
                  base_in    = req_base;
                  idx_in     = '0;
                  cnt_in     = '0;
                  res_acc_in = 1'b1;
                  state_in   = ST_SCAN;
               end else begin
                  res_dist_in = fallback_ff;
                  res_acc_in  = 1'b0;
                  state_in    = ST_DONE;
               end
            end
         end
         // rank the pivot against all entries: count smaller and not-larger ones
         ST_SCAN: begin
            if (cnt_ff == '0) begin
               lt_in = '0;
               le_in = '0;
            end
            if (cnt_ff == CNT_W'(1)) begin
               vi_in = entry;
            end
            if (cnt_ff >= CNT_W'(2) && cnt_ff <= CNT_W'(WINDOW + 1)) begin
               lt_in = lt_ff + CW'(cmp_lt);
               le_in = le_ff + CW'(cmp_lt || cmp_eq);
            end
            if (cnt_ff == CNT_W'(WINDOW + 2)) begin
               // pivot occupies sorted positions lt .. le-1
               if (lt_ff <= CW'(K_LO) && CW'(K_LO) < le_ff) begin
                  mid_lo_in = vi_ff;
               end
               if (lt_ff <= CW'(K_HI) && CW'(K_HI) < le_ff) begin
                  mid_hi_in = vi_ff;
               end
               cnt_in = '0;
               if (idx_ff == IW'(WINDOW - 1)) begin
                  state_in = ST_SUM;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_SUM: begin
            sum_in   = SUM_W'(mid_lo_ff) + SUM_W'(mid_hi_ff);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PROD_W'(sum_ff) * PROD_W'(scale_ff);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (dist_full > (PROD_W-DIST_SHIFT+1)'(DIST_MAX)) begin
               res_dist_in = DIST_MAX;
            end else begin
               res_dist_in = dist_full[DIST_W-1:0];
            end
            state_in = ST_DONE;
         end
         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = res_dist_ff;
               rsp_acc_in   = res_acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff     <= base_in;
      vi_ff       <= vi_in;
      lt_ff       <= lt_in;
      le_ff       <= le_in;
      mid_lo_ff   <= mid_lo_in;
      mid_hi_ff   <= mid_hi_in;
      sum_ff      <= sum_in;
      prod_ff     <= prod_in;
      res_dist_ff <= res_dist_in;
      res_acc_ff  <= res_acc_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_acc_ff  <= rsp_acc_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_accepted = rsp_acc_ff;

   // a transfer always starts work
   a_xfer_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_SCAN || state_ff == ST_DONE))
      else $error("transfer did not leave idle");

   // scan counter stays inside one pivot pass
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cnt_ff <= CNT_W'(WINDOW + 2))
      else $error("scan counter out of range");

   // rank counts remain ordered
   a_rank_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && cnt_ff > CNT_W'(1)) |-> (lt_ff <= le_ff))
      else $error("rank counts inconsistent");

   // a new result only comes from the hand-off state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result loaded outside hand-off");

   // rejected items report the fallback distance
   a_reject_fallback: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !in_window) |=> (res_dist_ff == fallback_ff && !res_acc_ff))
      else $error("rejected item lost fallback");

endmodule
